// ===== hw/rtl/distance_lod_update_gate_assert.svh =====
// assertion macros for the distance lod update gate
// expects clk_i and rst_ni in the scope that uses them
`ifndef DISTANCE_LOD_UPDATE_GATE_ASSERT_SVH
`define DISTANCE_LOD_UPDATE_GATE_ASSERT_SVH

// checked only while out of reset
`define DLUG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define DLUG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/dlug_pkg.sv =====
// shared types, codes and constants of the distance lod update gate
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dlug_pkg;

  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned DistSqW   = 48;
  localparam int unsigned RadiusW   = 15;
  localparam int unsigned ExtentW   = 25;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ReadyW    = 7;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned KeyW      = 28;
  localparam int unsigned MagW      = 32;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned D2W       = SqW + 2;
  localparam int unsigned JobDepth  = 2;
  localparam int unsigned ResDepth  = 2;

  localparam int unsigned DefWarmupFrames = 120;
  localparam int unsigned DefCoordBits    = 24;

  localparam logic [DistSqW-1:0] NearReset  = 48'd132710400;
  localparam logic [DistSqW-1:0] MidReset   = 48'd530841600;
  localparam logic [DistSqW-1:0] FarReset   = 48'd1677721600;
  localparam logic [RadiusW-1:0] RadReset   = 15'd1536;
  localparam logic [ExtentW-1:0] ExtXyReset = 25'd2560;
  localparam logic [ExtentW-1:0] ExtZReset  = 25'd3072;
  localparam logic [CountW-1:0]  QuietReset = 16'd24;

  localparam logic [AddrW-1:0]  AddrLow  = 32'h0001_0000;
  localparam logic [AddrW-1:0]  AddrHigh = 32'hFFE0_0000;
  localparam logic [FrameW-1:0] HashMul  = 32'd2654435761;
  localparam logic [10:0]       FootMul  = 11'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    RegNear   = 4'd0,
    RegMid    = 4'd1,
    RegFar    = 4'd2,
    RegRadius = 4'd3,
    RegExtXy  = 4'd4,
    RegExtZ   = 4'd5,
    RegQuiet  = 4'd6,
    RegStand  = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ActEval   = 2'd0,
    ActCamOn  = 2'd1,
    ActCamOff = 2'd2,
    ActFrame  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    RsnHeld     = 4'd0,
    RsnNotReady = 4'd1,
    RsnStand    = 4'd2,
    RsnQuiet    = 4'd3,
    RsnAddr     = 4'd4,
    RsnSize     = 4'd5,
    RsnNear     = 4'd6,
    RsnFoot     = 4'd7,
    RsnPhase    = 4'd8,
    RsnNoEval   = 4'd9
  } reason_e;

  typedef enum logic [1:0] {
    BandMid     = 2'd0,
    BandFar     = 2'd1,
    BandVeryFar = 2'd2,
    BandNone    = 2'd3
  } band_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkMul,
    BkSum,
    BkEval,
    BkOut
  } bk_state_e;

  typedef struct packed {
    logic               done;
    reason_e            reason;
    logic [RadiusW-1:0] radius;
    logic [MagW-1:0]    mag_x;
    logic [MagW-1:0]    mag_y;
    logic [MagW-1:0]    mag_z;
    logic [KeyW-1:0]    key;
    logic [FrameW-1:0]  frame;
  } job_t;

  typedef struct packed {
    logic    hold;
    reason_e reason;
    band_e   band;
  } res_t;

  typedef struct packed {
    logic [DistSqW-1:0] near_sq;
    logic [DistSqW-1:0] mid_sq;
    logic [DistSqW-1:0] far_sq;
  } band_cfg_t;

  typedef struct packed {
    logic job_pop;
    logic res_push;
  } bk_status_t;

  // true when the value is a multiple of three, by folding digits of base 2^k
  function automatic logic div3(input logic [FrameW-1:0] v);
    logic [16:0] s1;
    logic [9:0]  s2;
    logic [6:0]  s3;
    logic [5:0]  s4;
    logic [4:0]  s5;
    logic [3:0]  s6;
    logic [2:0]  s7;
    logic [1:0]  s8;
    s1 = 17'(v[31:16]) + 17'(v[15:0]);
    s2 = 10'(s1[16:8]) + 10'(s1[7:0]);
    s3 = 7'(s2[9:4]) + 7'(s2[3:0]);
    s4 = 6'(s3[6:2]) + 6'(s3[1:0]);
    s5 = 5'(s4[5:2]) + 5'(s4[1:0]);
    s6 = 4'(s5[4:2]) + 4'(s5[1:0]);
    s7 = 3'(s6[3:2]) + 3'(s6[1:0]);
    s8 = 2'(s7[2]) + s7[1:0];
    return (s8 == 2'd0) || (s8 == 2'd3);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dlug_fifo.sv =====
// small first-in first-out queue used between and behind the gate stages
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module dlug_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlug_front.sv =====
// front end: configuration registers, frame and camera state, early rejection
// depends on dlug_pkg
`timescale 1ns / 1ps
`default_nettype none

module dlug_front
  import dlug_pkg::*;
#(
  parameter int unsigned WARMUP_FRAMES = DefWarmupFrames,
  parameter int unsigned COORD_BITS    = DefCoordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   action_i,
  input  logic [AddrW-1:0]             model_addr_i,
  input  logic signed [15:0]           radius_i,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_z_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_z_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         cfg_write_i,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  output job_t                         job_o,
  output band_cfg_t                    bcfg_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned WideW = ((CB > ExtentW) ? CB : ExtentW) + 1;

  logic [DistSqW-1:0] near_q, mid_q, far_q;
  logic [RadiusW-1:0] max_rad_q;
  logic [ExtentW-1:0] ext_xy_q, ext_z_q;
  logic [CountW-1:0]  quiet_q;
  logic               stand_q;

  logic [FrameW-1:0]  frame_q;
  logic [CountW-1:0]  this_q, last_q;
  logic signed [CB-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic               cam_valid_q;
  logic [ReadyW-1:0]  ready_q;

  logic signed [CB:0] ex, ey, ez, dx, dy, dz;
  logic [CB:0]        ax, ay, az;
  logic               rad_bad, ext_bad;
  action_e            act;

  assign act = action_e'(action_i);

  function automatic logic ext_fail(input logic signed [CB:0] e,
                                    input logic [ExtentW-1:0] lim);
    return e[CB] || (e == '0) || (WideW'(e[CB-1:0]) > WideW'(lim));
  endfunction

  assign ex = {box_max_x_i[CB-1], box_max_x_i} - {box_min_x_i[CB-1], box_min_x_i};
  assign ey = {box_max_y_i[CB-1], box_max_y_i} - {box_min_y_i[CB-1], box_min_y_i};
  assign ez = {box_max_z_i[CB-1], box_max_z_i} - {box_min_z_i[CB-1], box_min_z_i};
  assign dx = {pos_x_i[CB-1], pos_x_i} - {cam_x_q[CB-1], cam_x_q};
  assign dy = {pos_y_i[CB-1], pos_y_i} - {cam_y_q[CB-1], cam_y_q};
  assign dz = {pos_z_i[CB-1], pos_z_i} - {cam_z_q[CB-1], cam_z_q};
  assign ax = dx[CB] ? -dx : dx;
  assign ay = dy[CB] ? -dy : dy;
  assign az = dz[CB] ? -dz : dz;

  assign rad_bad = radius_i[15] || (radius_i == '0) || (radius_i[14:0] > max_rad_q);
  assign ext_bad = ext_fail(ex, ext_xy_q) || ext_fail(ey, ext_xy_q) || ext_fail(ez, ext_z_q);

  // early classification, checks in priority order
  always_comb begin
    job_o        = '0;
    job_o.radius = radius_i[14:0];
    job_o.mag_x  = MagW'(ax[CB-1:0]);
    job_o.mag_y  = MagW'(ay[CB-1:0]);
    job_o.mag_z  = MagW'(az[CB-1:0]);
    job_o.key    = model_addr_i[AddrW-1:4];
    job_o.frame  = frame_q;
    job_o.done   = 1'b1;
    job_o.reason = RsnNoEval;
    if (act == ActEval) begin
      if (!cam_valid_q || (ready_q < ReadyW'(WARMUP_FRAMES))) begin
        job_o.reason = RsnNotReady;
      end else if (stand_q) begin
        job_o.reason = RsnStand;
      end else if (last_q < quiet_q) begin
        job_o.reason = RsnQuiet;
      end else if ((model_addr_i < AddrLow) || (model_addr_i > AddrHigh)) begin
        job_o.reason = RsnAddr;
      end else if (rad_bad || ext_bad) begin
        job_o.reason = RsnSize;
      end else begin
        job_o.done   = 1'b0;
        job_o.reason = RsnHeld;
      end
    end
  end

  assign bcfg_o = '{near_sq: near_q, mid_sq: mid_q, far_sq: far_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q    <= NearReset;
      mid_q     <= MidReset;
      far_q     <= FarReset;
      max_rad_q <= RadReset;
      ext_xy_q  <= ExtXyReset;
      ext_z_q   <= ExtZReset;
      quiet_q   <= QuietReset;
      stand_q   <= 1'b0;
    end else if (cfg_write_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegNear:   near_q    <= cfg_data_i;
        RegMid:    mid_q     <= cfg_data_i;
        RegFar:    far_q     <= cfg_data_i;
        RegRadius: max_rad_q <= cfg_data_i[RadiusW-1:0];
        RegExtXy:  ext_xy_q  <= cfg_data_i[ExtentW-1:0];
        RegExtZ:   ext_z_q   <= cfg_data_i[ExtentW-1:0];
        RegQuiet:  quiet_q   <= cfg_data_i[CountW-1:0];
        RegStand:  stand_q   <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      this_q      <= '0;
      last_q      <= '0;
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      cam_z_q     <= '0;
      cam_valid_q <= 1'b0;
      ready_q     <= '0;
    end else if (accept_i) begin
      unique case (act)
        ActEval: begin
          if (this_q != '1) begin
            this_q <= this_q + 1'b1;
          end
        end
        ActCamOn: begin
          cam_x_q     <= pos_x_i;
          cam_y_q     <= pos_y_i;
          cam_z_q     <= pos_z_i;
          cam_valid_q <= 1'b1;
          if (ready_q != '1) begin
            ready_q <= ready_q + 1'b1;
          end
        end
        ActCamOff: cam_valid_q <= 1'b0;
        ActFrame: begin
          frame_q <= frame_q + 1'b1;
          last_q  <= this_q;
          this_q  <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlug_back.sv =====
// back end: squared distance, footprint, banding and phase test
// depends on dlug_pkg
`timescale 1ns / 1ps
`default_nettype none

module dlug_back
  import dlug_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_empty_i,
  input  job_t       job_i,
  input  band_cfg_t  bcfg_i,
  input  logic       res_full_i,
  output res_t       res_o,
  output bk_status_t status_o
);

  // radius squared times the footprint factor, no overflow
  localparam int unsigned FootW = 2 * RadiusW + 11;

  bk_state_e state_q, state_d;

  job_t                 job_q;
  logic [SqW-1:0]       sq_x_q, sq_y_q, sq_z_q;
  logic [2*RadiusW-1:0] r2_q;
  logic [FrameW-1:0]    ph_q, t_q;
  logic [D2W-1:0]       d2_q;
  res_t                 res_q, res_d;

  logic [D2W+1:0]       d2x3, foot_lhs;
  logic                 is_near, is_foot, hit;
  band_e                band;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (!job_empty_i) begin
          state_d = job_i.done ? BkOut : BkMul;
        end
      end
      BkMul:  state_d = BkSum;
      BkSum:  state_d = BkEval;
      BkEval: state_d = BkOut;
      BkOut: begin
        if (!res_full_i) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    status_o = '0;
    unique case (state_q)
      BkIdle:  status_o.job_pop  = !job_empty_i;
      BkOut:   status_o.res_push = !res_full_i;
      default: ;
    endcase
  end

  // final decision from the registered squared distance
  assign d2x3     = (D2W + 2)'(d2_q) + (D2W + 2)'({d2_q, 1'b0});
  assign foot_lhs = (D2W + 2)'(FootW'(r2_q) * FootW'(FootMul));
  assign is_near  = d2_q <= D2W'(bcfg_i.near_sq);
  assign is_foot  = (d2_q[D2W-1:62] == '0) && (foot_lhs > d2x3);

  always_comb begin
    if (d2_q <= D2W'(bcfg_i.mid_sq)) begin
      band = BandMid;
      hit  = !t_q[0];
    end else if (d2_q <= D2W'(bcfg_i.far_sq)) begin
      band = BandFar;
      hit  = div3(t_q);
    end else begin
      band = BandVeryFar;
      hit  = (t_q[1:0] == 2'b00);
    end
    res_d = '{hold: 1'b0, reason: RsnHeld, band: BandNone};
    if (is_near) begin
      res_d.reason = RsnNear;
    end else if (is_foot) begin
      res_d.reason = RsnFoot;
    end else if (hit) begin
      res_d.reason = RsnPhase;
      res_d.band   = band;
    end else begin
      res_d.hold = 1'b1;
      res_d.band = band;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        job_q <= job_i;
        res_q <= '{hold: 1'b0, reason: job_i.reason, band: BandNone};
      end
      BkMul: begin
        sq_x_q <= job_q.mag_x * job_q.mag_x;
        sq_y_q <= job_q.mag_y * job_q.mag_y;
        sq_z_q <= job_q.mag_z * job_q.mag_z;
        r2_q   <= job_q.radius * job_q.radius;
        ph_q   <= FrameW'(FrameW'(job_q.key) * HashMul);
      end
      BkSum: begin
        d2_q <= D2W'(sq_x_q) + D2W'(sq_y_q) + D2W'(sq_z_q);
        t_q  <= job_q.frame + ph_q;
      end
      BkEval:  res_q <= res_d;
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/distance_lod_update_gate.sv =====
// top level of the distance lod update gate: front end, job queue, back end, result queue
// depends on dlug_pkg, dlug_fifo, dlug_front, dlug_back and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

// Decides per model evaluation whether the skeleton update is skipped this frame.
// Every accepted item gives exactly one result, in order. Items enter through a
// push/full queue face; the front end updates camera, frame and model counters at
// the accepting edge and rejects early (not ready, stand aside, quiet, bad address,
// size), so an item's answer reflects the state as it stood when it was pushed.
// A two-entry job queue decouples the front from the back end, which runs a
// sequencer over one set of multipliers: an evaluation that passes the early
// checks steps there through load, square, sum, decide and deliver, any other
// item through load and deliver. Results wait in a two-entry result queue, read
// through empty/pop. Configuration writes are always ready and take effect at the
// next edge; write only while no items are in flight.

module distance_lod_update_gate
  import dlug_pkg::*;
#(
  parameter int unsigned WARMUP_FRAMES = DefWarmupFrames,
  parameter int unsigned COORD_BITS    = DefCoordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item queue face
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action_i,
  input  logic [AddrW-1:0]             model_addr_i,
  input  logic signed [15:0]           radius_i,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_z_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_z_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  // result queue face
  output logic                         empty,
  input  logic                         pop,
  output logic                         hold_o,
  output logic [3:0]                   reason_o,
  output logic [1:0]                   band_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i
);

  job_t       job_in, job_out;
  band_cfg_t  bcfg;
  bk_status_t bk_status;
  res_t       res_in, res_out;
  logic       accept;
  logic       job_empty, res_full;

  // a transaction on the item face
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  dlug_front #(
    .WARMUP_FRAMES(WARMUP_FRAMES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i     (accept),
    .action_i,
    .model_addr_i,
    .radius_i,
    .box_min_x_i,
    .box_min_y_i,
    .box_min_z_i,
    .box_max_x_i,
    .box_max_y_i,
    .box_max_z_i,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .cfg_write_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .job_o        (job_in),
    .bcfg_o       (bcfg)
  );

  // decouples classification from the arithmetic
  dlug_fifo #(
    .DW   ($bits(job_t)),
    .DEPTH(JobDepth)
  ) u_job_q (
    .clk_i,
    .rst_ni,
    .push_i (accept),
    .wdata_i(job_in),
    .pop_i  (bk_status.job_pop),
    .rdata_o(job_out),
    .full_o (full),
    .empty_o(job_empty)
  );

  dlug_back u_back (
    .clk_i,
    .rst_ni,
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .bcfg_i     (bcfg),
    .res_full_i (res_full),
    .res_o      (res_in),
    .status_o   (bk_status)
  );

  // finished results wait here for the consumer
  dlug_fifo #(
    .DW   ($bits(res_t)),
    .DEPTH(ResDepth)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i (bk_status.res_push),
    .wdata_i(res_in),
    .pop_i  (pop),
    .rdata_o(res_out),
    .full_o (res_full),
    .empty_o(empty)
  );

  assign hold_o   = res_out.hold;
  assign reason_o = res_out.reason;
  assign band_o   = res_out.band;

  `include "distance_lod_update_gate_assert.svh"

  // back end never delivers into a full result queue
  `DLUG_ASSERT(a_res_push_room, bk_status.res_push |-> !res_full, "result pushed into full queue")
  // back end only loads a job that is there
  `DLUG_ASSERT_ALWAYS(a_job_pop_avail, bk_status.job_pop |-> !job_empty, "job taken from empty queue")
  // a held result always carries a real band
  `DLUG_ASSERT(a_hold_band, (!empty && hold_o) |-> (reason_o == RsnHeld && band_o != BandNone), "hold without band")

endmodule

`default_nettype wire

// ===== tb/tb_distance_lod_update_gate.sv =====
// self-checking testbench of the distance lod update gate: directed table, then random frames
// depends on dlug_pkg and the distance_lod_update_gate top level
`timescale 1ns / 1ps

module tb_distance_lod_update_gate;
  import dlug_pkg::*;

  localparam int unsigned CW       = DefCoordBits;
  localparam int unsigned WARMUP   = DefWarmupFrames;
  localparam int unsigned SEG_LEN  = 220;
  localparam int          LIMIT    = 400000;
  // an index past the register list, written to show it is ignored
  localparam logic [CfgIdxW-1:0] RegUnused = 4'd12;

  typedef struct {
    action_e              act;
    logic [AddrW-1:0]     addr;
    logic signed [15:0]   radius;
    logic signed [CW-1:0] bmin [3];
    logic signed [CW-1:0] bmax [3];
    logic signed [CW-1:0] pos  [3];
  } gate_item_t;

  typedef struct {
    int         reps;
    gate_item_t it;
    bit         typed;
    reason_e    rsn;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [1:0]           action_i;
  logic [AddrW-1:0]     model_addr_i;
  logic signed [15:0]   radius_i;
  logic signed [CW-1:0] box_min_x_i, box_min_y_i, box_min_z_i;
  logic signed [CW-1:0] box_max_x_i, box_max_y_i, box_max_z_i;
  logic signed [CW-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic                 empty;
  logic                 pop;
  logic                 hold_o;
  logic [3:0]           reason_o;
  logic [1:0]           band_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  distance_lod_update_gate DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .model_addr_i (model_addr_i),
    .radius_i     (radius_i),
    .box_min_x_i  (box_min_x_i),
    .box_min_y_i  (box_min_y_i),
    .box_min_z_i  (box_min_z_i),
    .box_max_x_i  (box_max_x_i),
    .box_max_y_i  (box_max_y_i),
    .box_max_z_i  (box_max_z_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .empty        (empty),
    .pop          (pop),
    .hold_o       (hold_o),
    .reason_o     (reason_o),
    .band_o       (band_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow copy of the gate registers
  logic [DistSqW-1:0] cfg_near, cfg_mid, cfg_far;
  logic [RadiusW-1:0] cfg_radius;
  logic [ExtentW-1:0] cfg_ext_xy, cfg_ext_z;
  logic [CountW-1:0]  cfg_quiet;
  logic               cfg_stand;

  // shadow copy of the gate state
  logic [FrameW-1:0]  frame_cnt;
  logic [CountW-1:0]  models_now, models_prev;
  longint             cam [3];
  logic               cam_valid;
  logic [ReadyW-1:0]  cam_ready;

  res_t      decisions_q [$];   // decisions still owed by the gate, oldest first
  stim_row_t table_q [$];
  int        mismatches;
  int        idle_pct;
  int        stall_pct;
  int        cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit: a hung handshake or a lost decision ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("distance_lod_update_gate regression: fail");
      $finish;
    end
  end

  // decision for one accepted transaction, advancing the shadow state the same way
  function automatic res_t gate_decide(input gate_item_t it);
    res_t              r;
    longint            rad, ex, ey, ez, dx, dy, dz;
    longint unsigned   d2;
    logic [FrameW-1:0] phase;
    logic [FrameW-1:0] slot;
    int                stride;
    r.hold   = 1'b0;
    r.reason = RsnNoEval;
    r.band   = BandNone;
    case (it.act)
      ActEval: begin
        if (models_now != '1) models_now++;
        rad = it.radius;
        ex  = longint'(it.bmax[0]) - longint'(it.bmin[0]);
        ey  = longint'(it.bmax[1]) - longint'(it.bmin[1]);
        ez  = longint'(it.bmax[2]) - longint'(it.bmin[2]);
        dx  = longint'(it.pos[0]) - cam[0];
        dy  = longint'(it.pos[1]) - cam[1];
        dz  = longint'(it.pos[2]) - cam[2];
        // 25-bit differences: the squared sum never saturates at this coordinate width
        d2  = dx * dx + dy * dy + dz * dz;
        if (!cam_valid || cam_ready < WARMUP) r.reason = RsnNotReady;
        else if (cfg_stand) r.reason = RsnStand;
        else if (models_prev < cfg_quiet) r.reason = RsnQuiet;
        else if (it.addr < AddrLow || it.addr > AddrHigh) r.reason = RsnAddr;
        else if (rad <= 0 || rad > cfg_radius ||
                 ex <= 0 || ex > cfg_ext_xy ||
                 ey <= 0 || ey > cfg_ext_xy ||
                 ez <= 0 || ez > cfg_ext_z) r.reason = RsnSize;
        else if (d2 <= cfg_near) r.reason = RsnNear;
        // r^2 > 0.0015 d2 in exact integer form
        else if (rad * rad * 2000 > d2 * 3) r.reason = RsnFoot;
        else begin
          if (d2 <= cfg_mid) begin
            r.band = BandMid;
            stride = 2;
          end else if (d2 <= cfg_far) begin
            r.band = BandFar;
            stride = 3;
          end else begin
            r.band = BandVeryFar;
            stride = 4;
          end
          phase = (it.addr >> 4) * HashMul;
          slot  = frame_cnt + phase;
          r.reason = (slot % stride == 0) ? RsnPhase : RsnHeld;
        end
        r.hold = (r.reason == RsnHeld);
      end
      ActCamOn: begin
        for (int a = 0; a < 3; a++) cam[a] = it.pos[a];
        cam_valid = 1'b1;
        if (cam_ready != '1) cam_ready++;
      end
      ActCamOff: cam_valid = 1'b0;
      default: begin
        frame_cnt++;
        models_prev = models_now;
        models_now  = '0;
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(input int reps, input action_e act, input logic [31:0] addr,
                                    input int rad, input int mnx, input int mny, input int mnz,
                                    input int mxx, input int mxy, input int mxz,
                                    input int px, input int py, input int pz,
                                    input bit typed, input reason_e rsn);
    stim_row_t s;
    s.reps      = reps;
    s.it.act    = act;
    s.it.addr   = addr;
    s.it.radius = 16'(rad);
    s.it.bmin   = '{CW'(mnx), CW'(mny), CW'(mnz)};
    s.it.bmax   = '{CW'(mxx), CW'(mxy), CW'(mxz)};
    s.it.pos    = '{CW'(px), CW'(py), CW'(pz)};
    s.typed     = typed;
    s.rsn       = rsn;
    return s;
  endfunction

  // any bit pattern in every field
  function automatic gate_item_t noise_item();
    gate_item_t it;
    it.act    = action_e'(2'($urandom_range(3, 0)));
    it.addr   = $urandom;
    it.radius = 16'($urandom);
    for (int a = 0; a < 3; a++) begin
      it.bmin[a] = CW'($urandom);
      it.bmax[a] = CW'($urandom);
      it.pos[a]  = CW'($urandom);
    end
    return it;
  endfunction

  function automatic gate_item_t camera_item();
    gate_item_t it;
    it     = noise_item();
    it.act = ActCamOn;
    for (int a = 0; a < 3; a++) begin
      it.pos[a] = CW'(int'($urandom_range(8000000, 0)) - 4000000);
    end
    return it;
  endfunction

  // a mostly well-formed evaluation near the camera, sometimes sitting on or just past a limit
  function automatic gate_item_t model_item();
    gate_item_t it;
    int         scale;
    int         pick;
    it.act    = ActEval;
    it.addr   = $urandom_range(AddrHigh, AddrLow);
    it.radius = 16'($urandom_range(1800, 1));
    for (int a = 0; a < 3; a++) begin
      scale      = 1 << $urandom_range(19, 10);
      it.bmin[a] = CW'(int'($urandom_range(4000000, 0)) - 2000000);
      it.bmax[a] = CW'(it.bmin[a] + int'($urandom_range(3300, 1)));
      it.pos[a]  = CW'(cam[a] + int'($urandom_range(2 * scale, 0)) - scale);
    end
    pick = $urandom_range(15, 0);
    case (pick)
      0: it.radius  = 16'(cfg_radius);
      1: it.radius  = 16'(cfg_radius) + 16'd1;
      2: it.addr    = AddrLow - 1;
      3: it.addr    = AddrLow;
      4: it.addr    = AddrHigh;
      5: it.addr    = AddrHigh + 1;
      6: it.bmax[0] = CW'(it.bmin[0] + cfg_ext_xy);
      7: it.bmax[2] = CW'(it.bmin[2] + cfg_ext_z + 1);
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input gate_item_t it, input bit typed, input reason_e rsn);
    res_t got;
    while ($urandom_range(99, 0) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    action_i     <= it.act;
    model_addr_i <= it.addr;
    radius_i     <= it.radius;
    box_min_x_i  <= it.bmin[0];
    box_min_y_i  <= it.bmin[1];
    box_min_z_i  <= it.bmin[2];
    box_max_x_i  <= it.bmax[0];
    box_max_y_i  <= it.bmax[1];
    box_max_z_i  <= it.bmax[2];
    pos_x_i      <= it.pos[0];
    pos_y_i      <= it.pos[1];
    pos_z_i      <= it.pos[2];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    got = gate_decide(it);
    if (typed) begin
      got.hold   = (rsn == RsnHeld);
      got.reason = rsn;
      got.band   = BandNone;
    end
    decisions_q.push_back(got);
  endtask

  // stop sending and let every owed decision come out, plus the back end's depth
  task automatic drain();
    push <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegNear:   cfg_near   = data[DistSqW-1:0];
      RegMid:    cfg_mid    = data[DistSqW-1:0];
      RegFar:    cfg_far    = data[DistSqW-1:0];
      RegRadius: cfg_radius = data[RadiusW-1:0];
      RegExtXy:  cfg_ext_xy = data[ExtentW-1:0];
      RegExtZ:   cfg_ext_z  = data[ExtentW-1:0];
      RegQuiet:  cfg_quiet  = data[CountW-1:0];
      RegStand:  cfg_stand  = data[0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [CfgDataW-1:0] near, input logic [CfgDataW-1:0] mid,
                         input logic [CfgDataW-1:0] far, input logic [CfgDataW-1:0] rad,
                         input logic [CfgDataW-1:0] exy, input logic [CfgDataW-1:0] ez,
                         input logic [CfgDataW-1:0] quiet, input logic [CfgDataW-1:0] stand);
    drain();
    cfg_write(RegNear, near);
    cfg_write(RegMid, mid);
    cfg_write(RegFar, far);
    cfg_write(RegRadius, rad);
    cfg_write(RegExtXy, exy);
    cfg_write(RegExtZ, ez);
    cfg_write(RegQuiet, quiet);
    cfg_write(RegStand, stand);
  endtask

  // random frames: warm the camera when needed, then batches of models closed by a frame mark
  task automatic run_frames(input int n, input bit pause_midway);
    int sent;
    int in_frame;
    int frame_len;
    int dice;
    sent      = 0;
    in_frame  = 0;
    frame_len = $urandom_range(40, 20);
    while (sent < n) begin
      dice = $urandom_range(99, 0);
      if (pause_midway && sent == n / 2) drain();
      if (!cam_valid || cam_ready < WARMUP) send_item(camera_item(), 1'b0, RsnHeld);
      else if (in_frame >= frame_len || dice < 3) begin
        gate_item_t mark;
        mark     = noise_item();
        mark.act = ActFrame;
        send_item(mark, 1'b0, RsnHeld);
        in_frame  = 0;
        frame_len = $urandom_range(40, 20);
      end else if (dice < 5) send_item(noise_item(), 1'b0, RsnHeld);
      else if (dice < 9) send_item(camera_item(), 1'b0, RsnHeld);
      else if (dice < 10) begin
        gate_item_t off;
        off     = noise_item();
        off.act = ActCamOff;
        send_item(off, 1'b0, RsnHeld);
      end else begin
        send_item(model_item(), 1'b0, RsnHeld);
        in_frame++;
      end
      sent++;
    end
  endtask

  // result side: random stalls on pop, every popped transaction checked in order
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (decisions_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected decision: hold %0d reason %0d band %0d", hold_o, reason_o, band_o);
      end else begin
        want = decisions_q.pop_front();
        if (hold_o !== want.hold || reason_o !== want.reason || band_o !== want.band) begin
          mismatches++;
          if (mismatches <= 10)
            $display("decision mismatch: expected hold %0d reason %0d band %0d, got %0d %0d %0d",
                     want.hold, want.reason, want.band, hold_o, reason_o, band_o);
        end
      end
    end
    pop <= rst_ni && ($urandom_range(99, 0) >= stall_pct);
  end

  initial begin
    stim_row_t s;
    cycles       = 0;
    mismatches   = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni       = 1'b0;
    push         <= 1'b0;
    action_i     <= ActEval;
    model_addr_i <= '0;
    radius_i     <= '0;
    box_min_x_i  <= '0;
    box_min_y_i  <= '0;
    box_min_z_i  <= '0;
    box_max_x_i  <= '0;
    box_max_y_i  <= '0;
    box_max_z_i  <= '0;
    pos_x_i      <= '0;
    pos_y_i      <= '0;
    pos_z_i      <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= RegNear;
    cfg_data_i   <= '0;

    // reset values of registers and state
    cfg_near   = NearReset;
    cfg_mid    = MidReset;
    cfg_far    = FarReset;
    cfg_radius = RadReset;
    cfg_ext_xy = ExtXyReset;
    cfg_ext_z  = ExtZReset;
    cfg_quiet  = QuietReset;
    cfg_stand  = 1'b0;
    frame_cnt   = '0;
    models_now  = '0;
    models_prev = '0;
    cam         = '{0, 0, 0};
    cam_valid   = 1'b0;
    cam_ready   = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset the camera is not ready: extreme fields still give not ready
    table_q.push_back(row(1, ActEval, 32'h0, -32768, -8388608, -8388608, -8388608,
                          8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                          1, RsnNotReady));
    table_q.push_back(row(1, ActEval, 32'hFFFF_FFFF, 32767, 8388607, 8388607, 8388607,
                          -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                          1, RsnNotReady));
    // non-evaluate actions never decide anything
    table_q.push_back(row(1, ActCamOn, 32'h0, 0, 0, 0, 0, 0, 0, 0,
                          8388607, 8388607, 8388607, 1, RsnNoEval));
    table_q.push_back(row(1, ActCamOff, 32'h0, 0, 0, 0, 0, 0, 0, 0,
                          -8388608, -8388608, -8388608, 1, RsnNoEval));
    table_q.push_back(row(1, ActFrame, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, RsnNoEval));
    table_q.push_back(row(1, ActCamOn, 32'h0, 0, 0, 0, 0, 0, 0, 0,
                          -8388608, -8388608, -8388608, 1, RsnNoEval));
    // camera valid but still warming up
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnNotReady));
    // warm-up ramp to the origin, then a full frame of models so the quiet check passes
    table_q.push_back(row(121, ActCamOn, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, RsnNoEval));
    table_q.push_back(row(24, ActEval, 32'h0012_3450, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 0, RsnHeld));
    table_q.push_back(row(1, ActFrame, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, RsnNoEval));
    // eligible model in the mid band, then the address edges
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 0, RsnHeld));
    table_q.push_back(row(1, ActEval, 32'h0000_FFFF, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnAddr));
    table_q.push_back(row(1, ActEval, 32'hFFE0_0001, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnAddr));
    table_q.push_back(row(1, ActEval, 32'h0001_0000, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 0, RsnHeld));
    table_q.push_back(row(1, ActEval, 32'hFFE0_0000, 256, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 0, RsnHeld));
    // size rejections: zero and negative radius, zero extent, radius and extents one past the limit
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 0, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnSize));
    table_q.push_back(row(1, ActEval, 32'h0012_3450, -1, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnSize));
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 1537, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnSize));
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 0, 256, 256,
                          20000, 0, 0, 1, RsnSize));
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 2561, 256, 256,
                          20000, 0, 0, 1, RsnSize));
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 256, 256, 3073,
                          20000, 0, 0, 1, RsnSize));
    // largest radius, too big on screen at this distance
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 1536, 0, 0, 0, 256, 256, 256,
                          20000, 0, 0, 1, RsnFoot));
    // exactly on the near distance
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 256, 256, 256,
                          11520, 0, 0, 1, RsnNear));
    // far and very far bands
    table_q.push_back(row(1, ActEval, 32'h0012_3450, 256, 0, 0, 0, 256, 256, 256,
                          30000, 0, 0, 0, RsnHeld));
    table_q.push_back(row(1, ActEval, 32'h0012_3458, 256, 0, 0, 0, 256, 256, 256,
                          60000, 0, 0, 0, RsnHeld));

    foreach (table_q[i]) begin
      s = table_q[i];
      repeat (s.reps) send_item(s.it, s.typed, s.rsn);
    end

    // random part: the idling pattern cycles through four phases; the registers are
    // rewritten before every segment but the first
    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      case (seg)
        1, 4, 6: cfg_all(CfgDataW'($urandom_range(200000000, 0)),
                         CfgDataW'($urandom_range(900000000, 200000000)),
                         48'($urandom_range(2000000000, 0)) + 48'd900000000,
                         CfgDataW'($urandom_range(4000, 256)),
                         CfgDataW'($urandom_range(6000, 1000)),
                         CfgDataW'($urandom_range(6000, 1000)),
                         CfgDataW'($urandom_range(30, 0)),
                         CfgDataW'($urandom_range(3, 0) == 0));
        2: cfg_all('1, '1, '1, '1, '1, '1, '1, '1);
        3: begin
          cfg_all('0, '0, '0, '0, '0, '0, '0, '0);
          cfg_write(RegUnused, '1);
        end
        5: cfg_all(NearReset, MidReset, FarReset, CfgDataW'(RadReset), CfgDataW'(ExtXyReset),
                   CfgDataW'(ExtZReset), CfgDataW'(QuietReset), CfgDataW'(1));
        7: cfg_all(NearReset, MidReset, FarReset, CfgDataW'(RadReset), CfgDataW'(ExtXyReset),
                   CfgDataW'(ExtZReset), CfgDataW'(QuietReset), CfgDataW'(0));
        default: ;
      endcase
      run_frames(SEG_LEN, seg == 1);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("distance_lod_update_gate regression: pass");
    end else begin
      $display("distance_lod_update_gate regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dlug_pkg.sv
hw/rtl/dlug_fifo.sv
hw/rtl/dlug_front.sv
hw/rtl/dlug_back.sv
hw/rtl/distance_lod_update_gate.sv
tb/tb_distance_lod_update_gate.sv
